[src/wav_pcm16_header_checker_core_macros.svh]
// assertion macros for the wav header checker
`ifndef WAV_PCM16_HEADER_CHECKER_CORE_MACROS_SVH
`define WAV_PCM16_HEADER_CHECKER_CORE_MACROS_SVH

// implication checked every clock outside reset
`define WHC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define WHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/whc_pkg.sv]
// package: types, constants and helpers for the wav header checker
`timescale 1ns / 1ps
package whc_pkg;
  localparam int MAX_CHUNKS_DEF = 4096;
  localparam int CHUNK_W = 13;
  localparam int POS_W = 33;
  localparam int FSIZE_W = 40;

  localparam logic [4:0] ST_OK        = 5'd0;
  localparam logic [4:0] ST_SHORT     = 5'd1;
  localparam logic [4:0] ST_NOT_RIFF  = 5'd2;
  localparam logic [4:0] ST_RIFF_SIZE = 5'd3;
  localparam logic [4:0] ST_CHUNKS    = 5'd4;
  localparam logic [4:0] ST_TRUNC     = 5'd5;
  localparam logic [4:0] ST_PAST_END  = 5'd6;
  localparam logic [4:0] ST_DUP_FMT   = 5'd7;
  localparam logic [4:0] ST_FMT_SHORT = 5'd8;
  localparam logic [4:0] ST_NOT_PCM   = 5'd9;
  localparam logic [4:0] ST_CHANNELS  = 5'd10;
  localparam logic [4:0] ST_RATE      = 5'd11;
  localparam logic [4:0] ST_ALIGN     = 5'd12;
  localparam logic [4:0] ST_DUP_DATA  = 5'd13;
  localparam logic [4:0] ST_EMPTY     = 5'd14;
  localparam logic [4:0] ST_MISSING   = 5'd15;
  localparam logic [4:0] ST_PARTIAL   = 5'd16;
  localparam logic [4:0] ST_EOF       = 5'd17;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_RIFF = 3'd1;
  localparam logic [2:0] PH_CHDR = 3'd2;
  localparam logic [2:0] PH_FMT  = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;

  localparam logic [31:0] TAG_RIFF = 32'h46464952;
  localparam logic [31:0] TAG_WAVE = 32'h45564157;
  localparam logic [31:0] TAG_FMT  = 32'h20746d66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;

  localparam logic [2:0] CFG_FILE_SIZE = 3'd0;

  // verdict handed from the parser to the output stage
  typedef struct packed {
    logic [4:0]  status;
    logic [15:0] rate;
    logic [1:0]  chans;
    logic [32:0] offset;
    logic [31:0] bytes;
  } verdict_t;
endpackage

[src/whc_parser.sv]
// front part: byte parser that produces one verdict per file
`timescale 1ns / 1ps
module whc_parser import whc_pkg::*; #(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [FSIZE_W-1:0] file_size,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte_value,
  input  logic               in_first,
  input  logic               in_last,
  output logic               v_valid,
  input  logic               v_ready,
  output verdict_t           v_data
);
  logic [2:0]        phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  rend_r, rend_nxt;
  logic [63:0]       hdr_r, hdr_nxt;
  logic [127:0]      fmt_r, fmt_nxt;
  logic [POS_W-1:0]  skip_r, skip_nxt;
  logic [CHUNK_W-1:0] cnt_r, cnt_nxt;
  logic              ffmt_r, ffmt_nxt, fdata_r, fdata_nxt;
  logic [15:0]       rate_r, rate_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic [POS_W-1:0]  poff_r, poff_nxt;
  logic [31:0]       psz_r, psz_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        gi_r, gi_nxt;
  logic              emit;
  logic [4:0]        code;
  logic              take;

  assign in_ready = v_ready;
  assign take = in_valid && in_ready;

  always_comb begin
    logic        go;
    logic [4:0]  c;
    logic        arr;
    logic [31:0] sz;
    logic [32:0] padded;
    logic [32:0] left;
    logic [15:0] enc, chw, align, bits;
    logic [31:0] rate, brate;
    logic [47:0] prod;
    logic [POS_W:0] re;
    phase_nxt = phase_r; pos_nxt = pos_r; rend_nxt = rend_r; hdr_nxt = hdr_r;
    fmt_nxt = fmt_r; skip_nxt = skip_r; cnt_nxt = cnt_r; ffmt_nxt = ffmt_r;
    fdata_nxt = fdata_r; rate_nxt = rate_r; ch_nxt = ch_r; poff_nxt = poff_r;
    psz_nxt = psz_r; done_nxt = done_r; gi_nxt = gi_r;
    emit = 1'b0; code = ST_OK;
    go = 1'b1; c = ST_OK; arr = 1'b0;
    sz = '0; padded = '0; left = '0; enc = '0; chw = '0; align = '0; bits = '0;
    rate = '0; brate = '0; prod = '0; re = '0;
    if (take) begin
      if (in_first) begin
        phase_nxt = PH_IDLE; pos_nxt = '0; rend_nxt = '0; hdr_nxt = '0; fmt_nxt = '0;
        skip_nxt = '0; cnt_nxt = '0; ffmt_nxt = 1'b0; fdata_nxt = 1'b0;
        rate_nxt = '0; ch_nxt = '0; poff_nxt = '0; psz_nxt = '0; gi_nxt = '0;
        done_nxt = 1'b0;
        if (file_size < FSIZE_W'(12)) begin
          go = 1'b0; c = ST_SHORT;
        end else begin
          phase_nxt = PH_RIFF;
        end
      end
      if (go && !done_nxt) begin
        unique case (phase_nxt)
          PH_RIFF: begin
            fmt_nxt = {in_byte_value, fmt_nxt[127:8]};
            gi_nxt = gi_nxt + 5'd1;
            pos_nxt = pos_nxt + POS_W'(1);
            if (gi_nxt == 5'd12) begin
              // twelve bytes sit in the top of the shift
              sz = fmt_nxt[95:64];
              re = (POS_W+1)'(sz) + (POS_W+1)'(8);
              if (fmt_nxt[63:32] != TAG_RIFF || fmt_nxt[127:96] != TAG_WAVE) begin
                go = 1'b0; c = ST_NOT_RIFF;
              end else if (sz < 32'd4 || {7'd0, re} > {1'b0, file_size}) begin
                go = 1'b0; c = ST_RIFF_SIZE;
              end else begin
                rend_nxt = re[POS_W-1:0]; cnt_nxt = '0; arr = 1'b1;
              end
            end
          end
          PH_CHDR: begin
            hdr_nxt = {in_byte_value, hdr_nxt[63:8]};
            gi_nxt = gi_nxt + 5'd1;
            pos_nxt = pos_nxt + POS_W'(1);
            if (gi_nxt == 5'd8) begin
              sz = hdr_nxt[63:32];
              padded = {1'b0, sz} + {32'd0, sz[0]};
              left = rend_nxt - pos_nxt;
              if (padded > left) begin
                go = 1'b0; c = ST_PAST_END;
              end else if (hdr_nxt[31:0] == TAG_FMT) begin
                if (ffmt_nxt) begin go = 1'b0; c = ST_DUP_FMT; end
                else if (sz < 32'd16) begin go = 1'b0; c = ST_FMT_SHORT; end
                else begin
                  skip_nxt = padded - 33'd16; phase_nxt = PH_FMT; gi_nxt = '0;
                end
              end else if (hdr_nxt[31:0] == TAG_DATA && fdata_nxt) begin
                go = 1'b0; c = ST_DUP_DATA;
              end else if (hdr_nxt[31:0] == TAG_DATA && sz == 32'd0) begin
                go = 1'b0; c = ST_EMPTY;
              end else begin
                if (hdr_nxt[31:0] == TAG_DATA) begin
                  poff_nxt = pos_nxt; psz_nxt = sz; fdata_nxt = 1'b1;
                end
                skip_nxt = padded;
                if (padded == '0) arr = 1'b1;
                else phase_nxt = PH_SKIP;
              end
            end
          end
          PH_FMT: begin
            fmt_nxt = {in_byte_value, fmt_nxt[127:8]};
            gi_nxt = gi_nxt + 5'd1;
            pos_nxt = pos_nxt + POS_W'(1);
            if (gi_nxt == 5'd16) begin
              enc = fmt_nxt[15:0]; chw = fmt_nxt[31:16]; rate = fmt_nxt[63:32];
              brate = fmt_nxt[95:64]; align = fmt_nxt[111:96]; bits = fmt_nxt[127:112];
              prod = {16'd0, rate} * {32'd0, align};
              if (enc != 16'd1 || bits != 16'd16) begin go = 1'b0; c = ST_NOT_PCM; end
              else if (chw != 16'd1 && chw != 16'd2) begin go = 1'b0; c = ST_CHANNELS; end
              else if (rate != 32'd24000 && rate != 32'd44100 && rate != 32'd48000) begin
                go = 1'b0; c = ST_RATE;
              end else if (align != {chw[14:0], 1'b0} || prod != {16'd0, brate}) begin
                go = 1'b0; c = ST_ALIGN;
              end else begin
                rate_nxt = rate[15:0]; ch_nxt = chw[1:0]; ffmt_nxt = 1'b1;
                if (skip_nxt == '0) arr = 1'b1;
                else phase_nxt = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            pos_nxt = pos_nxt + POS_W'(1);
            if (skip_nxt != '0) skip_nxt = skip_nxt - POS_W'(1);
            if (skip_nxt == '0) arr = 1'b1;
          end
          default: begin
            go = 1'b1;
          end
        endcase
        if (go && arr) begin
          if (pos_nxt >= rend_nxt) begin
            go = 1'b0;
            if (!ffmt_nxt || !fdata_nxt) c = ST_MISSING;
            else if (ch_nxt == 2'd1 ? psz_nxt[0] : (psz_nxt[1:0] != 2'd0)) c = ST_PARTIAL;
            else c = ST_OK;
          end else if (32'(cnt_nxt) >= 32'(MAX_CHUNKS)) begin
            go = 1'b0; c = ST_CHUNKS;
          end else begin
            cnt_nxt = cnt_nxt + CHUNK_W'(1);
            if (rend_nxt - pos_nxt < POS_W'(8)) begin go = 1'b0; c = ST_TRUNC; end
            else begin phase_nxt = PH_CHDR; gi_nxt = '0; end
          end
        end
        if (go && in_last) begin go = 1'b0; c = ST_EOF; end
      end
      if (!go) begin
        emit = 1'b1; code = c; done_nxt = 1'b1; phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; done_r <= 1'b1; gi_r <= '0; cnt_r <= '0;
      ffmt_r <= 1'b0; fdata_r <= 1'b0; pos_r <= '0; rend_r <= '0; skip_r <= '0;
      hdr_r <= '0; fmt_r <= '0; rate_r <= '0; ch_r <= '0; poff_r <= '0; psz_r <= '0;
      v_valid <= 1'b0;
    end else begin
      phase_r <= phase_nxt; done_r <= done_nxt; gi_r <= gi_nxt; cnt_r <= cnt_nxt;
      ffmt_r <= ffmt_nxt; fdata_r <= fdata_nxt; pos_r <= pos_nxt; rend_r <= rend_nxt;
      skip_r <= skip_nxt; hdr_r <= hdr_nxt; fmt_r <= fmt_nxt; rate_r <= rate_nxt;
      ch_r <= ch_nxt; poff_r <= poff_nxt; psz_r <= psz_nxt;
      if (v_ready || !v_valid) v_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && (v_ready || !v_valid)) begin
      v_data.status <= code;
      if (code == ST_OK) begin
        v_data.rate <= rate_nxt; v_data.chans <= ch_nxt;
        v_data.offset <= poff_nxt; v_data.bytes <= psz_nxt;
      end else begin
        v_data.rate <= '0; v_data.chans <= '0; v_data.offset <= '0; v_data.bytes <= '0;
      end
    end
  end
endmodule

[src/whc_result.sv]
// back part: two-entry queue and frame count for verdicts
`timescale 1ns / 1ps
module whc_result import whc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        v_valid,
  output logic        v_ready,
  input  verdict_t    v_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_status,
  output logic [15:0] out_sample_rate,
  output logic [1:0]  out_channel_count,
  output logic [32:0] out_data_offset,
  output logic [31:0] out_data_bytes,
  output logic [30:0] out_frame_count
);
  verdict_t    q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;
  verdict_t    h;

  assign v_ready = (cnt_r != 2'd2);
  assign push = v_valid && v_ready;
  assign pop = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign h = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= v_data;
  end

  assign out_status = h.status;
  assign out_sample_rate = h.rate;
  assign out_channel_count = h.chans;
  assign out_data_offset = h.offset;
  assign out_data_bytes = h.bytes;
  // frame size is two or four bytes, so the count is a shift
  assign out_frame_count = (h.chans == 2'd2) ? {1'b0, h.bytes[31:2]} : h.bytes[31:1];
endmodule

[src/wav_pcm16_header_checker_core.sv]
// top level of the wav pcm16 header checker
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_byte_value, in_first, in_last
// out     | output    | out_valid, out_ready, out_status .. out_frame_count
// cfg     | input     | cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr, cfg_pwdata
// one byte per cycle while the verdict queue has room; a verdict is registered in
// the parser's output register, then shows on out_valid once it enters the queue
// the parser takes bytes while the two-entry verdict queue has room
// reset is synchronous, active low; file_size clears to zero
`timescale 1ns / 1ps
module wav_pcm16_header_checker_core import whc_pkg::*; #(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_first,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_status,
  output logic [15:0] out_sample_rate,
  output logic [1:0]  out_channel_count,
  output logic [32:0] out_data_offset,
  output logic [31:0] out_data_bytes,
  output logic [30:0] out_frame_count
);
  logic [FSIZE_W-1:0] fsize_r;
  logic     v_valid, v_ready;
  verdict_t v_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_FILE_SIZE) ? {24'd0, fsize_r} : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsize_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == CFG_FILE_SIZE) begin
      fsize_r <= cfg_pwdata[FSIZE_W-1:0];
    end
  end

  whc_parser #(.MAX_CHUNKS(MAX_CHUNKS)) u_parser (
    .clk, .rst_n, .file_size(fsize_r), .in_valid, .in_ready, .in_byte_value,
    .in_first, .in_last, .v_valid, .v_ready, .v_data
  );

  whc_result u_result (
    .clk, .rst_n, .v_valid, .v_ready, .v_data, .out_valid, .out_ready, .out_status,
    .out_sample_rate, .out_channel_count, .out_data_offset, .out_data_bytes,
    .out_frame_count
  );
endmodule

[src/whc_checker.sv]
// port checker for the wav header checker, bound to the top level
`timescale 1ns / 1ps
`include "wav_pcm16_header_checker_core_macros.svh"
module whc_checker import whc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_status,
  input logic [1:0]  out_channel_count,
  input logic [15:0] out_sample_rate,
  input logic [31:0] out_data_bytes
);
  `WHC_ASSERT_IMP(a_status_range, out_valid, out_status <= ST_EOF, "status out of range")
  `WHC_ASSERT_IMP(a_err_zero, out_valid && out_status != ST_OK,
    out_sample_rate == 16'd0 && out_channel_count == 2'd0, "error item carries data")
  `WHC_ASSERT_IMP(a_ok_chans, out_valid && out_status == ST_OK,
    out_channel_count == 2'd1 || out_channel_count == 2'd2, "ok item lacks channels")
  `WHC_ASSERT_NEXT(a_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_data_bytes), "stalled item changed")
endmodule

bind wav_pcm16_header_checker_core whc_checker u_whc_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_status, .out_channel_count,
  .out_sample_rate, .out_data_bytes
);
